/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define SYNTH to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/bwct_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwct_pkg
// Types and constants shared by the block-work datapath.
// ---------------------------------------------------------------------------
package bwct_pkg;

   localparam int WORD_W     = 64;
   localparam int TARGET_W   = 256;
   localparam int COMPACT_W  = 32;
   localparam int MANT_W     = 23;
   localparam int DIV_STEPS  = 256;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [1:0] STATUS_ZERO     = 2'd3;

   // one decoded item as it sits in the queue
   typedef struct packed {
      logic [1:0]          status;
      logic [TARGET_W-1:0] target;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_state_type;

endpackage

/* hdl/bwct_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwct_front
// Accepts compact words, classifies them and expands the 256-bit target.
// ---------------------------------------------------------------------------
module bwct_front (
   input  logic                           req_valid,
   input  logic [bwct_pkg::COMPACT_W-1:0] req_compact_bits,
   output logic                           req_stall,
   input  bwct_pkg::queue_state_type      q_state,
   output bwct_pkg::push_type             push
);

   logic [7:0]                    size;
   logic                          sign;
   logic [bwct_pkg::MANT_W-1:0]   mant;
   logic [bwct_pkg::MANT_W-1:0]   mant_adj;
   logic [7:0]                    size_m3;
   logic [7:0]                    shift_bits;
   logic                          nz;
   logic                          ovf;
   logic [bwct_pkg::TARGET_W-1:0] target;
   logic [1:0]                    status;

   assign size = req_compact_bits[31:24];
   assign sign = req_compact_bits[23];
   assign mant = req_compact_bits[22:0];

   // small exponents drop whole mantissa bytes off the right
   always_comb begin
      priority if (size == 8'd0) begin
         mant_adj = '0;
      end else if (size == 8'd1) begin
         mant_adj = mant >> 16;
      end else if (size == 8'd2) begin
         mant_adj = mant >> 8;
      end else begin
         mant_adj = mant;
      end
   end

   assign nz  = (mant_adj != '0);
   assign ovf = nz && ((size > 8'd34) ||
                       ((mant_adj > 23'h0000ff) && (size > 8'd33)) ||
                       ((mant_adj > 23'h00ffff) && (size > 8'd32)));

   // byte shift; only meaningful for sizes 4..34
   assign size_m3    = size - 8'd3;
   assign shift_bits = {size_m3[4:0], 3'b000};

   always_comb begin
      if (size <= 8'd3) begin
         target = {{(bwct_pkg::TARGET_W-bwct_pkg::MANT_W){1'b0}}, mant_adj};
      end else begin
         target = {{(bwct_pkg::TARGET_W-bwct_pkg::MANT_W){1'b0}}, mant} << shift_bits;
      end
   end

   always_comb begin
      priority if (nz && sign) begin
         status = bwct_pkg::STATUS_NEGATIVE;
      end else if (ovf) begin
         status = bwct_pkg::STATUS_OVERFLOW;
      end else if (!nz) begin
         status = bwct_pkg::STATUS_ZERO;
      end else begin
         status = bwct_pkg::STATUS_OK;
      end
   end

   assign req_stall           = q_state.full;
   assign push.valid          = req_valid && !q_state.full;
   assign push.entry.status   = status;
   assign push.entry.target   = target;

endmodule

/* hdl/bwct_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwct_queue
// Short FIFO of decoded items between the front and the divider.
// ---------------------------------------------------------------------------
module bwct_queue #(
   parameter int DEPTH = 2   // 2 or more
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bwct_pkg::push_type        push,
   input  logic                      pop,
   output bwct_pkg::entry_type       head,
   output bwct_pkg::queue_state_type q_state
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bwct_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign q_state.empty = (count_ff == '0);
   assign q_state.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push       = push.valid && !q_state.full;
   assign do_pop        = pop && !q_state.empty;
   assign head          = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

/* hdl/bwct_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwct_back
// Restoring radix-2 divide (~t)/(t+1), increment, and the result register.
// ---------------------------------------------------------------------------
module bwct_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bwct_pkg::queue_state_type            q_state,
   input  bwct_pkg::entry_type                  head,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bwct_pkg::WORD_W-1:0]          rsp_work_word0,
   output logic [bwct_pkg::WORD_W-1:0]          rsp_work_word1,
   output logic [bwct_pkg::WORD_W-1:0]          rsp_work_word2,
   output logic [bwct_pkg::WORD_W-1:0]          rsp_work_word3,
   output logic [1:0]                           rsp_status
);

   localparam int TW = bwct_pkg::TARGET_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } back_state_type;

   back_state_type                     state_ff, state_in;
   logic [bwct_pkg::STEP_CNT_W-1:0]    step_ff, step_in;
   logic [TW-1:0]                      target_ff, target_in;
   logic [TW-1:0]                      nq_ff, nq_in;    // numerator out, quotient in
   logic [TW-1:0]                      rem_ff, rem_in;
   logic [1:0]                         status_ff, status_in;
   logic [TW:0]                        rem_sh;
   logic [TW+1:0]                      diff;
   logic                               ge;
   logic [TW-1:0]                      work;
   logic                               out_free, load;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]                      work_ff, work_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;

   // r >= t+1  <=>  r - t - 1 does not go negative
   assign rem_sh = {rem_ff, nq_ff[TW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, target_ff} - {{(TW+1){1'b0}}, 1'b1};
   assign ge     = !diff[TW+1];

   assign work     = (status_ff == bwct_pkg::STATUS_OK) ? nq_ff + 1'b1 : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (state_ff == ST_FIN) && out_free;
   assign pop      = (state_ff == ST_IDLE) && !q_state.empty;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      target_in = target_ff;
      nq_in     = nq_ff;
      rem_in    = rem_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               target_in = head.target;
               nq_in     = ~head.target;
               rem_in    = '0;
               status_in = head.status;
               step_in   = '0;
               state_in  = (head.status == bwct_pkg::STATUS_OK) ? ST_DIV : ST_FIN;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[TW-1:0] : rem_sh[TW-1:0];
            nq_in   = {nq_ff[TW-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == bwct_pkg::STEP_CNT_W'(bwct_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      work_in       = work_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         work_in       = work;
         rsp_status_in = status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      nq_ff         <= nq_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      work_ff       <= work_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_work_word0 = work_ff[63:0];
   assign rsp_work_word1 = work_ff[127:64];
   assign rsp_work_word2 = work_ff[191:128];
   assign rsp_work_word3 = work_ff[255:192];

endmodule

/* hdl/block_work_from_compact_target_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_work_from_compact_target_top
// Expected block work 2^256/(target+1) from a compact target word.
// ---------------------------------------------------------------------------
// Input channel req_*: one 32-bit compact word per item, taken when
// req_valid is high and req_stall low. Result channel rsp_*: four 64-bit
// work words and a 2-bit status per item, in input order, one per item.
// A front decoder classifies each word and expands the target into a
// short queue; the back end runs a radix-2 restoring divider, one
// quotient bit per cycle for 256 steps, then increments the quotient.
// A valid item occupies the divider through pop, 256 division steps
// and finish; the next item is popped only after that. Negative,
// overflow and zero targets skip the divider and give zero work.
// The front keeps accepting while the queue has room (QUEUE_DEPTH items);
// req_stall rises only when it is full. A stalled result holds in the
// output register while the divider goes on with the next item.
// Reset (synchronous, active high) empties the queue and the output
// register and returns the divider to idle; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module block_work_from_compact_target_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_compact_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_work_word0,
   output logic [63:0] rsp_work_word1,
   output logic [63:0] rsp_work_word2,
   output logic [63:0] rsp_work_word3,
   output logic [1:0]  rsp_status
);

   bwct_pkg::push_type        push;
   bwct_pkg::entry_type       head;
   bwct_pkg::queue_state_type q_state;
   logic                      pop;
   logic                      rsp_ok;
   logic                      work_zero;

   bwct_front u_front (
      .req_valid        (req_valid),
      .req_compact_bits (req_compact_bits),
      .req_stall        (req_stall),
      .q_state          (q_state),
      .push             (push)
   );

   bwct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .head    (head),
      .q_state (q_state)
   );

   bwct_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_state        (q_state),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_work_word0 (rsp_work_word0),
      .rsp_work_word1 (rsp_work_word1),
      .rsp_work_word2 (rsp_work_word2),
      .rsp_work_word3 (rsp_work_word3),
      .rsp_status     (rsp_status)
   );

   assign rsp_ok    = (rsp_status == bwct_pkg::STATUS_OK);
   assign work_zero = (rsp_work_word0 == '0) && (rsp_work_word1 == '0) &&
                      (rsp_work_word2 == '0) && (rsp_work_word3 == '0);

   // rejected targets carry no work
   `ASSERT_IMPLIES(a_err_zero_work, clock, reset, rsp_valid && !rsp_ok, work_zero)
   // a valid target always gives at least one unit of work
   `ASSERT_IMPLIES(a_ok_nonzero_work, clock, reset, rsp_valid && rsp_ok, !work_zero)
   // a full queue must hold off the sender
   `ASSERT_IMPLIES(a_full_stalls, clock, reset, q_state.full, req_stall)
   // queue cannot be empty and full at once
   `ASSERT_IMPLIES(a_queue_flags, clock, reset, q_state.empty, !q_state.full)

endmodule
